// ===== src/bce_pkg.sv =====
package bce_pkg;

  localparam int CHAR_W      = 8;
  localparam int POS_W       = 5;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int BUILTIN_LEN = 24;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CUSTOM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS0     = 3'd2;

  localparam logic [CHAR_W-1:0] CH_A       = 8'h41;
  localparam logic [CHAR_W-1:0] CH_B       = 8'h42;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_I       = 8'h49;
  localparam logic [CHAR_W-1:0] CH_J       = 8'h4a;
  localparam logic [CHAR_W-1:0] CH_U       = 8'h55;
  localparam logic [CHAR_W-1:0] CH_V       = 8'h56;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

  // Built-in alphabet: A..Z without J and V.
  localparam logic [CHAR_W-1:0] BUILTIN_ALPHA [BUILTIN_LEN] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
    8'h49, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51,
    8'h52, 8'h53, 8'h54, 8'h55, 8'h57, 8'h58, 8'h59, 8'h5a
  };

  // One code to emit: optional leading space and the alphabet position.
  typedef struct packed {
    logic             space;
    logic [POS_W-1:0] pos;
  } bce_cmd_t;

  function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = c - CASE_DIFF;
    end
    return r;
  endfunction

endpackage

// ===== src/bce_front.sv =====
module bce_front #(
  parameter int ALPHABET_MAX = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bce_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bce_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_fire_i,
  input  logic [bce_pkg::CHAR_W-1:0]         source_byte_i,
  input  logic                               message_start_i,
  output logic                               push_o,
  output bce_pkg::bce_cmd_t                  cmd_o
);
  import bce_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ALPHABET_MAX);

  logic                  use_custom_q;
  logic [LEN_W-1:0]      len_q;
  logic [CHAR_W-1:0]     alpha_q [ALPHABET_MAX];
  logic                  pending_q, pending_d;

  logic [LEN_W-1:0]      len_eff;
  logic [CHAR_W-1:0]     ch_fold;
  logic [CHAR_W-1:0]     ch_builtin;
  logic                  hit_custom, hit_builtin, hit;
  logic [POS_W-1:0]      pos_custom, pos_builtin;
  logic                  pending_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_custom_q <= 1'b0;
      len_q        <= '0;
      for (int k = 0; k < ALPHABET_MAX; k++) begin
        alpha_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_USE_CUSTOM) begin
        use_custom_q <= cfg_data_i[0];
      end
      if (cfg_idx_i == CFG_LENGTH) begin
        len_q <= cfg_data_i[LEN_W-1:0];
      end
      for (int k = 0; k < ALPHABET_MAX; k++) begin
        if (cfg_idx_i == CFG_CHARS0 + CFG_IDX_W'(k / 8)) begin
          alpha_q[k] <= cfg_data_i[(k % 8) * CHAR_W +: CHAR_W];
        end
      end
    end
  end

  assign len_eff = (len_q > MAX_LEN) ? MAX_LEN : len_q;
  assign ch_fold = fold_upper(source_byte_i);

  always_comb begin
    if (ch_fold == CH_J) begin
      ch_builtin = CH_I;
    end else if (ch_fold == CH_V) begin
      ch_builtin = CH_U;
    end else begin
      ch_builtin = ch_fold;
    end
  end

  // Parallel compares; scanning from the top down leaves the lowest match.
  always_comb begin
    hit_custom = 1'b0;
    pos_custom = '0;
    for (int i = ALPHABET_MAX - 1; i >= 0; i--) begin
      if (LEN_W'(i) < len_eff && fold_upper(alpha_q[i]) == ch_fold) begin
        hit_custom = 1'b1;
        pos_custom = POS_W'(i);
      end
    end
  end

  always_comb begin
    hit_builtin = 1'b0;
    pos_builtin = '0;
    for (int i = BUILTIN_LEN - 1; i >= 0; i--) begin
      if (BUILTIN_ALPHA[i] == ch_builtin) begin
        hit_builtin = 1'b1;
        pos_builtin = POS_W'(i);
      end
    end
  end

  assign hit         = use_custom_q ? hit_custom : hit_builtin;
  assign pending_eff = pending_q & ~message_start_i;

  always_comb begin
    pending_d = pending_q;
    if (in_fire_i) begin
      if (hit) begin
        pending_d = 1'b0;
      end else begin
        pending_d = ~message_start_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
    end
  end

  assign push_o      = in_fire_i & hit;
  assign cmd_o.space = pending_eff;
  assign cmd_o.pos   = use_custom_q ? pos_custom : pos_builtin;

endmodule

// ===== src/bce_fifo.sv =====
module bce_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bce_pkg::bce_cmd_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output bce_pkg::bce_cmd_t  pop_data_o,
  output logic               empty_o
);
  import bce_pkg::*;

  bce_cmd_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   cnt_q, cnt_d;
  logic                    do_push, do_pop;

  assign full_o     = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow a push");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> wr_ptr_q == rd_ptr_q)
    else $error("empty queue with unequal pointers");

endmodule

// ===== src/bce_back.sv =====
module bce_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  bce_pkg::bce_cmd_t           cmd_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bce_pkg::CHAR_W-1:0]  m_axis_tdata,
  output logic                        m_axis_tlast
);
  import bce_pkg::*;

  logic               busy_q;
  logic               space_q;
  logic [POS_W-1:0]   pos_q;
  logic [2:0]         bit_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic               out_last_q;
  logic               slot_free, emit, finishing;

  assign slot_free = ~out_valid_q | m_axis_tready;
  assign emit      = busy_q & slot_free;
  assign finishing = emit & ~space_q & (bit_q == '0);
  assign pop_o     = ~empty_i & (~busy_q | finishing);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      space_q     <= 1'b0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        if (space_q) begin
          space_q <= 1'b0;
        end else if (bit_q != '0) begin
          bit_q <= bit_q - 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q  <= 1'b1;
        space_q <= cmd_i.space;
        bit_q   <= 3'(POS_W - 1);
      end else if (finishing) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pos_q <= cmd_i.pos;
    end
    if (emit) begin
      if (space_q) begin
        out_char_q <= CH_SPACE;
        out_last_q <= 1'b0;
      end else begin
        out_char_q <= pos_q[bit_q] ? CH_B : CH_A;
        out_last_q <= (bit_q == '0);
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_char_q == CH_A || out_char_q == CH_B || out_char_q == CH_SPACE))
    else $error("illegal output character");

  a_last_not_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> out_char_q != CH_SPACE)
    else $error("run ends on a space");

  a_space_then_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && space_q) |=> busy_q)
    else $error("space emitted without a following code");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> bit_q <= 3'(POS_W - 1))
    else $error("bit counter out of range");

endmodule

// ===== src/bacon_cipher_encoder.sv =====
// Bacon cipher encoder. Each input transfer carries one source byte (tdata) and a
// message-start flag (tuser). A byte that matches the active alphabet produces five
// output transfers of 'A'/'B' (position MSB first), preceded by a space when an
// unmatched byte came since the last match in the same message; tlast marks the
// final character of the run. Unmatched bytes produce nothing. The front end
// classifies a byte in the cycle it is accepted and queues matches in a four-entry
// queue, so input is taken every cycle until the queue fills. Output is paced by
// the serializer at one character per cycle while the receiver is ready.
// Write configuration only while the block is idle.
module bacon_cipher_encoder #(
  parameter int ALPHABET_MAX = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bce_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bce_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] source_byte
  input  logic                               s_axis_tuser,  // [0] message_start
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [7:0] code_char
  output logic                               m_axis_tlast
);
  import bce_pkg::*;

  logic      in_fire, push, full, pop, empty;
  bce_cmd_t  push_cmd, pop_cmd;

  assign s_axis_tready = ~full;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  bce_front #(
    .ALPHABET_MAX(ALPHABET_MAX)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_fire_i      (in_fire),
    .source_byte_i  (s_axis_tdata),
    .message_start_i(s_axis_tuser),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  bce_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_cmd),
    .empty_o    (empty)
  );

  bce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ===== tb/bce_code_checker.sv =====
// Watches the configuration port and both stream channels. Every accepted
// source byte is run through a local Bacon encoder, and every accepted code
// character is compared with the oldest character still owed.
module bce_code_checker #(
  parameter int ALPHABET_MAX = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           src_valid_i,
  input  logic                           src_ready_i,
  input  logic [bce_pkg::CHAR_W-1:0]     src_byte_i,
  input  logic                           src_first_i,
  input  logic                           code_valid_i,
  input  logic                           code_ready_i,
  input  logic [bce_pkg::CHAR_W-1:0]     code_char_i,
  input  logic                           code_last_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             codes_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bce_pkg::*;

  localparam int LETTERS        = 26;
  localparam int ALPHA_WORDS    = 4;
  localparam int CHARS_PER_WORD = 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } code_t;

  code_t                 owed_codes [$];
  logic                  custom_sel;
  logic [LEN_W-1:0]      alpha_len;
  logic [CFG_DATA_W-1:0] alpha_words [ALPHA_WORDS];
  logic                  owe_space;

  function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      return c - CASE_DIFF;
    end
    return c;
  endfunction

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    int w;
    w = int'(idx) - int'(CFG_CHARS0);
    if (idx == CFG_USE_CUSTOM) begin
      custom_sel = data[0];
    end else if (idx == CFG_LENGTH) begin
      alpha_len = data[LEN_W-1:0];
    end else if (w >= 0 && w < ALPHA_WORDS) begin
      alpha_words[w] = data;
    end
  endtask

  // Appends the code characters that one source byte produces.
  task automatic encode_byte(input logic [CHAR_W-1:0] raw, input logic first);
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] letter;
    logic              hit;
    logic [POS_W-1:0]  idx;
    int                n;
    int                pos;
    c   = to_upper(raw);
    hit = 1'b0;
    idx = '0;
    if (first) begin
      owe_space = 1'b0;
    end
    if (custom_sel) begin
      n = (int'(alpha_len) > ALPHABET_MAX) ? ALPHABET_MAX : int'(alpha_len);
      for (int i = 0; i < n; i++) begin
        letter = alpha_words[i / CHARS_PER_WORD][(i % CHARS_PER_WORD) * CHAR_W +: CHAR_W];
        if (!hit && to_upper(letter) == c) begin
          hit = 1'b1;
          idx = POS_W'(i);
        end
      end
    end else begin
      if (c == CH_J) begin
        c = CH_I;
      end else if (c == CH_V) begin
        c = CH_U;
      end
      // The built-in alphabet is A to Z with J and V left out.
      pos = 0;
      for (int k = 0; k < LETTERS; k++) begin
        letter = CH_A + CHAR_W'(k);
        if (letter != CH_J && letter != CH_V) begin
          if (!hit && letter == c) begin
            hit = 1'b1;
            idx = POS_W'(pos);
          end
          pos++;
        end
      end
    end
    if (!hit) begin
      if (!first) begin
        owe_space = 1'b1;
      end
    end else begin
      if (owe_space) begin
        owed_codes.push_back('{ch: CH_SPACE, last: 1'b0});
      end
      for (int b = POS_W - 1; b >= 0; b--) begin
        owed_codes.push_back('{ch: idx[b] ? CH_B : CH_A, last: (b == 0)});
      end
      owe_space = 1'b0;
    end
  endtask

  task automatic check_code(input logic [CHAR_W-1:0] ch, input logic last);
    code_t want;
    codes_o++;
    if (owed_codes.size() == 0) begin
      errors_o++;
      if (errors_o <= MAX_REPORTS) begin
        $display("%0t: unexpected code transfer, char %h last %b", $realtime, ch, last);
      end
    end else begin
      want = owed_codes.pop_front();
      if (ch !== want.ch || last !== want.last) begin
        errors_o++;
        if (errors_o <= MAX_REPORTS) begin
          $display("%0t: code mismatch, expected char %h last %b, got char %h last %b",
                   $realtime, want.ch, want.last, ch, last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_codes.delete();
      custom_sel = 1'b0;
      alpha_len  = '0;
      for (int i = 0; i < ALPHA_WORDS; i++) begin
        alpha_words[i] = '0;
      end
      owe_space = 1'b0;
      errors_o  = 0;
      pending_o = 0;
      codes_o   = 0;
    end else begin
      if (cfg_we_i) begin
        apply_write(cfg_idx_i, cfg_data_i);
      end
      if (src_valid_i && src_ready_i) begin
        encode_byte(src_byte_i, src_first_i);
      end
      if (code_valid_i && code_ready_i) begin
        check_code(code_char_i, code_last_i);
      end
      pending_o = owed_codes.size();
    end
  end

endmodule

// ===== tb/tb_bacon_cipher_encoder.sv =====
module tb_bacon_cipher_encoder;
  timeunit 1ns;
  timeprecision 1ps;
  import bce_pkg::*;

  localparam int ITEMS_PER_PHASE = 67;
  localparam int RANDOM_PHASES   = 6;
  localparam int SETTLE_CYCLES   = 16;
  localparam int REG_COUNT       = 6;
  localparam int ALPHA_WORDS     = 4;
  localparam int CHARS_PER_WORD  = 8;
  localparam int ALPHA_CAP       = 32;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  src_valid  = 1'b0;
  logic                  src_ready;
  logic [CHAR_W-1:0]     src_data   = '0;
  logic                  src_first  = 1'b0;
  logic                  code_valid;
  logic                  code_ready = 1'b0;
  logic [CHAR_W-1:0]     code_data;
  logic                  code_last;

  int mismatch_count;
  int pending_codes;
  int codes_checked;
  int items_sent     = 0;
  int settings_count = 1;
  bit no_idle        = 1'b0;

  // Copy of the active alphabet, so that random bytes can aim at it.
  logic                  cur_custom = 1'b0;
  logic [LEN_W-1:0]      cur_len    = '0;
  logic [CFG_DATA_W-1:0] cur_words [ALPHA_WORDS] = '{default: '0};

  always #6 clk = ~clk;

  bacon_cipher_encoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (src_valid),
    .s_axis_tready (src_ready),
    .s_axis_tdata  (src_data),
    .s_axis_tuser  (src_first),
    .m_axis_tvalid (code_valid),
    .m_axis_tready (code_ready),
    .m_axis_tdata  (code_data),
    .m_axis_tlast  (code_last)
  );

  bce_code_checker code_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .src_valid_i  (src_valid),
    .src_ready_i  (src_ready),
    .src_byte_i   (src_data),
    .src_first_i  (src_first),
    .code_valid_i (code_valid),
    .code_ready_i (code_ready),
    .code_char_i  (code_data),
    .code_last_i  (code_last),
    .errors_o     (mismatch_count),
    .pending_o    (pending_codes),
    .codes_o      (codes_checked)
  );

  function automatic logic [CHAR_W-1:0] maybe_flip_case(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] low;
    low = b | CASE_DIFF;
    if (low >= CH_LOWER_A && low <= CH_LOWER_Z && $urandom_range(0, 1) == 1) begin
      return b ^ CASE_DIFF;
    end
    return b;
  endfunction

  // Half letters, half arbitrary bytes, so duplicates and odd codes both show up.
  function automatic logic [CFG_DATA_W-1:0] rand_alpha_word();
    logic [CFG_DATA_W-1:0] w;
    for (int i = 0; i < CHARS_PER_WORD; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        w[i * CHAR_W +: CHAR_W] = maybe_flip_case(CH_A + CHAR_W'($urandom_range(0, 25)));
      end else begin
        w[i * CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(0, 255));
      end
    end
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_byte();
    logic [CHAR_W-1:0] b;
    int                r;
    int                p;
    int                n;
    r = $urandom_range(0, 99);
    n = (int'(cur_len) > ALPHA_CAP) ? ALPHA_CAP : int'(cur_len);
    if (r < 60 && cur_custom && n > 0) begin
      p = $urandom_range(0, n - 1);
      b = maybe_flip_case(cur_words[p / CHARS_PER_WORD][(p % CHARS_PER_WORD) * CHAR_W +: CHAR_W]);
    end else if (r < 80) begin
      b = maybe_flip_case(CH_A + CHAR_W'($urandom_range(0, 25)));
    end else begin
      b = CHAR_W'($urandom_range(0, 255));
    end
    return b;
  endfunction

  task automatic send_byte(input logic [CHAR_W-1:0] b, input logic first);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= b;
    src_first <= first;
    do @(posedge clk); while (!src_ready);
    items_sent++;
  endtask

  // Stops feeding bytes and waits until every owed code character has left,
  // plus a settling margin.
  task automatic wait_for_codes();
    src_valid <= 1'b0;
    @(negedge clk);
    while (pending_codes != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_alphabet(input logic custom, input logic [LEN_W-1:0] len,
                              input logic [CFG_DATA_W-1:0] w0,
                              input logic [CFG_DATA_W-1:0] w1,
                              input logic [CFG_DATA_W-1:0] w2,
                              input logic [CFG_DATA_W-1:0] w3);
    logic [CFG_DATA_W-1:0] vals [REG_COUNT];
    vals = '{CFG_DATA_W'(custom), CFG_DATA_W'(len), w0, w1, w2, w3};
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_USE_CUSTOM + CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we       <= 1'b0;
    cur_custom   = custom;
    cur_len      = len;
    cur_words    = '{w0, w1, w2, w3};
    settings_count++;
  endtask

  // Code characters leave whenever the receiver is ready; its stalls are random.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        code_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      code_ready <= 1'b1;
      do @(posedge clk); while (!code_valid);
    end
  end

  initial begin
    #2_000_000;
    $display("Run stopped: time budget exhausted.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] w0;
    logic [CFG_DATA_W-1:0] w1;
    logic [CFG_DATA_W-1:0] w2;
    logic [CFG_DATA_W-1:0] w3;
    int                    sent;
    int                    msg_len;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Built-in alphabet straight out of reset: case folding, J and V
    // substitution, separators and message starts that cancel them.
    send_byte("A", 1'b1);
    send_byte("z", 1'b0);
    send_byte("j", 1'b0);
    send_byte("V", 1'b0);
    send_byte(" ", 1'b0);
    send_byte("w", 1'b0);
    send_byte("1", 1'b1);
    send_byte("Y", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte("e", 1'b1);
    send_byte("k", 1'b0);
    wait_for_codes();

    // Full custom alphabet with a duplicate J, lower-case entries, a zero
    // byte, 0xFF and a space among its characters.
    w0 = 64'h407b314aff00764a;
    w1 = 64'h5251504f4e4d4c4b;
    w2 = 64'h7a79787776757473;
    w3 = 64'h7e017f4342412080;
    set_alphabet(1'b1, 6'd32, w0, w1, w2, w3);
    send_byte("j", 1'b1);
    send_byte("V", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte("I", 1'b0);
    send_byte("~", 1'b0);
    send_byte("S", 1'b0);
    send_byte(" ", 1'b0);
    wait_for_codes();

    // Empty alphabet matches nothing; an oversized length acts as 32.
    set_alphabet(1'b1, 6'd0, w0, w1, w2, w3);
    send_byte("J", 1'b1);
    wait_for_codes();
    set_alphabet(1'b1, 6'd63, w0, w1, w2, w3);
    send_byte("~", 1'b1);
    send_byte("v", 1'b0);
    wait_for_codes();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_alphabet(1'b0, LEN_W'($urandom_range(0, 63)), rand_alpha_word(),
                        rand_alpha_word(), rand_alpha_word(), rand_alpha_word());
        1: set_alphabet(1'b1, 6'd32, rand_alpha_word(), rand_alpha_word(),
                        rand_alpha_word(), rand_alpha_word());
        2: set_alphabet(1'b1, LEN_W'($urandom_range(1, 31)), rand_alpha_word(),
                        rand_alpha_word(), rand_alpha_word(), rand_alpha_word());
        3: set_alphabet(1'b1, 6'd63, '1, '0, rand_alpha_word(), rand_alpha_word());
        4: set_alphabet(1'b0, 6'd1, '0, '1, rand_alpha_word(), rand_alpha_word());
        default: set_alphabet(1'b1, LEN_W'($urandom_range(0, 63)), rand_alpha_word(),
                              rand_alpha_word(), rand_alpha_word(), rand_alpha_word());
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        msg_len = $urandom_range(1, 12);
        for (int k = 0; k < msg_len && sent < ITEMS_PER_PHASE; k++) begin
          send_byte(pick_byte(), k == 0 || $urandom_range(0, 31) == 0);
          sent++;
          if (sent % 20 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
          end
          if (ph == 2 && sent == ITEMS_PER_PHASE / 2) begin
            wait_for_codes();
          end
        end
      end
      wait_for_codes();
    end

    $display("Sent %0d source bytes over %0d alphabet settings (built-in, custom lengths 0, 32, 63",
             items_sent, settings_count);
    $display("and random); %0d code characters checked, %0d mismatching.",
             codes_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
